// ===== rtl/gmd_pkg.sv =====
// shared types, field widths and codes for the grid maze solver
package gmd_pkg;

    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;

    localparam int ACTION_W = 2;
    localparam int INDEX_W  = 12;
    localparam int CFG_W    = 7;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 1;

    localparam logic [CFG_W-1:0] CFG_DIM_RESET = 7'd64;

    localparam logic [REG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD  = 2'd0,
        ACT_SOLVE = 2'd1,
        ACT_READ  = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        MARK_FREE = 2'd0,
        MARK_WALL = 2'd1,
        MARK_PATH = 2'd2,
        MARK_DEAD = 2'd3
    } mark_t;

endpackage

// ===== rtl/gmd_if.sv =====
// request and response stream interfaces of the grid maze solver
interface gmd_req_if;
    import gmd_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [INDEX_W-1:0]  cell_index;
    logic                cell_free;

    modport source (output valid, action, cell_index, cell_free, input ready);
    modport sink   (input valid, action, cell_index, cell_free, output ready);
endinterface

interface gmd_rsp_if;
    import gmd_pkg::*;

    logic       valid;
    logic       ready;
    logic       path_found;
    logic [1:0] cell_mark;

    modport source (output valid, path_found, cell_mark, input ready);
    modport sink   (input valid, path_found, cell_mark, output ready);
endinterface

// ===== rtl/grid_maze_dfs_solver.sv =====
// grid maze solver: cell store, depth-first search sequencer and stack memory
// load and read requests: accepted one per cycle while the solver is idle and the
//   response path is not stalled; each response passes the stage after the memory read
//   and then the output register
// solve request: blocks new requests through the clearing pass and the corner checks,
//   then a step per direction tried, a probe per neighbor and a pop per backtrack
// reset: config registers go to 64, control state and last outcome clear; the cell
//   store and stack memory hold no reset and must be loaded before use
module grid_maze_dfs_solver #(
    parameter int MAX_WIDTH  = gmd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = gmd_pkg::DEF_MAX_HEIGHT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    gmd_req_if.sink                         req,
    gmd_rsp_if.source                       rsp,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [gmd_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [gmd_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [gmd_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import gmd_pkg::*;

    // derived sizes
    localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
    localparam int IDX_W = $clog2(CELLS);
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int WD_W  = $clog2(MAX_WIDTH + 1);
    localparam int HT_W  = $clog2(MAX_HEIGHT + 1);
    localparam int AR_W  = WD_W + HT_W;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_CLEAR  = 8'b0000_0010,
        ST_RD0    = 8'b0000_0100,
        ST_RDEND  = 8'b0000_1000,
        ST_CORNER = 8'b0001_0000,
        ST_STEP   = 8'b0010_0000,
        ST_CHECK  = 8'b0100_0000,
        ST_POP    = 8'b1000_0000
    } state_t;

    // one stack entry: cell, its row and column, and next direction to try
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [2:0]       dir;
    } stk_entry_t;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [CFG_W-1:0]     grid_width_reg;
    logic [CFG_W-1:0]     grid_height_reg;
    logic                 cfg_wr;
    logic [REG_IDX_W-1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[APB_ADDR_W-1 -: REG_IDX_W];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= CFG_DIM_RESET;
            grid_height_reg <= CFG_DIM_RESET;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_GRID_WIDTH:  grid_width_reg  <= pwdata[CFG_W-1:0];
                REG_GRID_HEIGHT: grid_height_reg <= pwdata[CFG_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_GRID_WIDTH:  prdata = APB_DATA_W'(grid_width_reg);
            REG_GRID_HEIGHT: prdata = APB_DATA_W'(grid_height_reg);
            default:         prdata = '0;
        endcase
    end

    // clamp to 1..max; zero acts as one
    logic [WD_W-1:0] w_eff;
    logic [HT_W-1:0] h_eff;
    logic [AR_W-1:0] area;

    always_comb
    begin
        if (grid_width_reg == '0)
            w_eff = WD_W'(1);
        else if (32'(grid_width_reg) > 32'(MAX_WIDTH))
            w_eff = WD_W'(MAX_WIDTH);
        else
            w_eff = WD_W'(grid_width_reg);

        if (grid_height_reg == '0)
            h_eff = HT_W'(1);
        else if (32'(grid_height_reg) > 32'(MAX_HEIGHT))
            h_eff = HT_W'(MAX_HEIGHT);
        else
            h_eff = HT_W'(grid_height_reg);

        area = AR_W'(w_eff) * AR_W'(h_eff);
    end

    // ------------------------------------------------------------------
    // cell store and stack memory, one write and one registered read each
    // ------------------------------------------------------------------
    logic [1:0]       cell_mem [CELLS];
    logic             cell_we;
    logic [IDX_W-1:0] cell_wa;
    logic [1:0]       cell_wd;
    logic             cell_re;
    logic [IDX_W-1:0] cell_ra;
    logic [1:0]       cell_rd_reg;

    always_ff @(posedge clk)
    begin
        if (cell_we)
            cell_mem[cell_wa] <= cell_wd;
        if (cell_re)
            cell_rd_reg <= cell_mem[cell_ra];
    end

    stk_entry_t       stk_mem [CELLS];
    logic             stk_we;
    logic [IDX_W-1:0] stk_wa;
    stk_entry_t       stk_wd;
    logic             stk_re;
    logic [IDX_W-1:0] stk_ra;
    stk_entry_t       stk_rd_reg;

    always_ff @(posedge clk)
    begin
        if (stk_we)
            stk_mem[stk_wa] <= stk_wd;
        if (stk_re)
            stk_rd_reg <= stk_mem[stk_ra];
    end

    // ------------------------------------------------------------------
    // search state
    // ------------------------------------------------------------------
    state_t           state_reg, state_next;
    logic [IDX_W:0]   sweep_reg, sweep_next;
    logic [IDX_W:0]   depth_reg, depth_next;
    logic             last_found_reg, last_found_next;
    logic             wall0_reg, wall0_next;
    logic [WD_W-1:0]  w_reg, w_next;
    logic [HT_W-1:0]  h_reg, h_next;
    logic [IDX_W-1:0] end_reg, end_next;
    stk_entry_t       top_reg, top_next;
    stk_entry_t       nb_reg, nb_next;

    // response pipeline: stage after the memory read, then output register
    logic             p_valid_reg, p_valid_next;
    logic [1:0]       p_action_reg, p_action_next;
    logic             p_range_reg, p_range_next;
    logic             o_valid_reg, o_valid_next;
    logic             o_found_reg, o_found_next;
    logic [1:0]       o_mark_reg, o_mark_next;

    logic             acc;
    logic             p_move;
    logic             in_range;
    logic [IDX_W-1:0] in_addr;
    logic             nb_ok;
    stk_entry_t       nb_cand;
    logic [IDX_W:0]   depth_m1;
    logic [IDX_W:0]   depth_m2;
    logic [IDX_W:0]   sweep_m1;

    assign acc       = req.valid && req.ready;
    assign p_move    = p_valid_reg && (!o_valid_reg || rsp.ready) && (state_reg == ST_IDLE);
    assign req.ready = (state_reg == ST_IDLE) && (!p_valid_reg || p_move);
    assign in_range  = 32'(req.cell_index) < 32'(CELLS);
    assign in_addr   = IDX_W'(req.cell_index);
    assign depth_m1  = depth_reg - 1'b1;
    assign depth_m2  = depth_reg - 2'd2;
    assign sweep_m1  = sweep_reg - 1'b1;

    assign rsp.valid      = o_valid_reg;
    assign rsp.path_found = o_found_reg;
    assign rsp.cell_mark  = o_mark_reg;

    // neighbor of the top cell in its current direction: right, down, left, up
    always_comb
    begin
        nb_cand     = top_reg;
        nb_cand.dir = 3'd0;
        case (top_reg.dir[1:0])
            2'd0:
            begin
                nb_ok       = (32'(top_reg.col) + 32'd1) < 32'(w_reg);
                nb_cand.idx = top_reg.idx + IDX_W'(1);
                nb_cand.col = top_reg.col + COL_W'(1);
            end
            2'd1:
            begin
                nb_ok       = (32'(top_reg.row) + 32'd1) < 32'(h_reg);
                nb_cand.idx = top_reg.idx + IDX_W'(w_reg);
                nb_cand.row = top_reg.row + ROW_W'(1);
            end
            2'd2:
            begin
                nb_ok       = top_reg.col != '0;
                nb_cand.idx = top_reg.idx - IDX_W'(1);
                nb_cand.col = top_reg.col - COL_W'(1);
            end
            default:
            begin
                nb_ok       = top_reg.row != '0;
                nb_cand.idx = top_reg.idx - IDX_W'(w_reg);
                nb_cand.row = top_reg.row - ROW_W'(1);
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        sweep_next      = sweep_reg;
        depth_next      = depth_reg;
        last_found_next = last_found_reg;
        wall0_next      = wall0_reg;
        w_next          = w_reg;
        h_next          = h_reg;
        end_next        = end_reg;
        top_next        = top_reg;
        nb_next         = nb_reg;

        cell_we = 1'b0;
        cell_wa = '0;
        cell_wd = MARK_FREE;
        cell_re = 1'b0;
        cell_ra = '0;
        stk_we  = 1'b0;
        stk_wa  = '0;
        stk_wd  = top_reg;
        stk_re  = 1'b0;
        stk_ra  = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    case (req.action)
                        ACT_LOAD:
                        begin
                            cell_we = in_range;
                            cell_wa = in_addr;
                            cell_wd = req.cell_free ? MARK_FREE : MARK_WALL;
                        end
                        ACT_READ:
                        begin
                            cell_re = 1'b1;
                            cell_ra = in_addr;
                        end
                        ACT_SOLVE:
                        begin
                            // capture geometry for the whole solve
                            w_next     = w_eff;
                            h_next     = h_eff;
                            end_next   = IDX_W'(area - 1'b1);
                            sweep_next = '0;
                            state_next = ST_CLEAR;
                        end
                        default: ;
                    endcase
                end
            end
            ST_CLEAR:
            begin
                // read entry n while writing back entry n-1
                if (32'(sweep_reg) < 32'(CELLS))
                begin
                    cell_re = 1'b1;
                    cell_ra = sweep_reg[IDX_W-1:0];
                end
                if (sweep_reg != '0 &&
                    (cell_rd_reg == MARK_PATH || cell_rd_reg == MARK_DEAD))
                begin
                    cell_we = 1'b1;
                    cell_wa = sweep_m1[IDX_W-1:0];
                    cell_wd = MARK_FREE;
                end
                if (32'(sweep_reg) == 32'(CELLS))
                    state_next = ST_RD0;
                else
                    sweep_next = sweep_reg + 1'b1;
            end
            ST_RD0:
            begin
                cell_re    = 1'b1;
                cell_ra    = '0;
                state_next = ST_RDEND;
            end
            ST_RDEND:
            begin
                cell_re    = 1'b1;
                cell_ra    = end_reg;
                wall0_next = cell_rd_reg == MARK_WALL;
                state_next = ST_CORNER;
            end
            ST_CORNER:
            begin
                if (wall0_reg || cell_rd_reg == MARK_WALL)
                begin
                    last_found_next = 1'b0;
                    depth_next      = '0;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    cell_we = 1'b1;
                    cell_wa = '0;
                    cell_wd = MARK_PATH;
                    if (end_reg == '0)
                    begin
                        // single-cell grid: start is the end
                        last_found_next = 1'b1;
                        depth_next      = '0;
                        state_next      = ST_IDLE;
                    end
                    else
                    begin
                        top_next   = '0;
                        depth_next = (IDX_W+1)'(1);
                        state_next = ST_STEP;
                    end
                end
            end
            ST_STEP:
            begin
                if (top_reg.dir[2])
                begin
                    // all directions spent: dead end, backtrack
                    cell_we = 1'b1;
                    cell_wa = top_reg.idx;
                    cell_wd = MARK_DEAD;
                    if (depth_reg == (IDX_W+1)'(1))
                    begin
                        last_found_next = 1'b0;
                        depth_next      = '0;
                        state_next      = ST_IDLE;
                    end
                    else
                    begin
                        depth_next = depth_m1;
                        stk_re     = 1'b1;
                        stk_ra     = depth_m2[IDX_W-1:0];
                        state_next = ST_POP;
                    end
                end
                else
                begin
                    top_next.dir = top_reg.dir + 3'd1;
                    if (nb_ok)
                    begin
                        if (nb_cand.idx == end_reg)
                        begin
                            cell_we         = 1'b1;
                            cell_wa         = end_reg;
                            cell_wd         = MARK_PATH;
                            last_found_next = 1'b1;
                            depth_next      = '0;
                            state_next      = ST_IDLE;
                        end
                        else
                        begin
                            cell_re    = 1'b1;
                            cell_ra    = nb_cand.idx;
                            nb_next    = nb_cand;
                            state_next = ST_CHECK;
                        end
                    end
                end
            end
            ST_CHECK:
            begin
                if (cell_rd_reg == MARK_FREE && 32'(depth_reg) < 32'(CELLS))
                begin
                    // push: top goes to memory with its advanced direction
                    cell_we    = 1'b1;
                    cell_wa    = nb_reg.idx;
                    cell_wd    = MARK_PATH;
                    stk_we     = 1'b1;
                    stk_wa     = depth_m1[IDX_W-1:0];
                    stk_wd     = top_reg;
                    top_next   = nb_reg;
                    depth_next = depth_reg + 1'b1;
                end
                state_next = ST_STEP;
            end
            ST_POP:
            begin
                top_next   = stk_rd_reg;
                state_next = ST_STEP;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // response pipeline
    always_comb
    begin
        p_valid_next  = p_valid_reg;
        p_action_next = p_action_reg;
        p_range_next  = p_range_reg;
        o_valid_next  = o_valid_reg;
        o_found_next  = o_found_reg;
        o_mark_next   = o_mark_reg;

        if (rsp.ready)
            o_valid_next = 1'b0;
        if (p_move)
        begin
            p_valid_next = 1'b0;
            o_valid_next = 1'b1;
            o_found_next = last_found_reg;
            if (p_action_reg == ACT_READ)
            begin
                if (!p_range_reg)
                    o_mark_next = MARK_WALL;
                else if (cell_rd_reg == MARK_DEAD)
                    o_mark_next = MARK_FREE;
                else
                    o_mark_next = cell_rd_reg;
            end
            else
            begin
                o_mark_next = MARK_FREE;
            end
        end
        if (acc)
        begin
            p_valid_next  = 1'b1;
            p_action_next = req.action;
            p_range_next  = in_range;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            depth_reg      <= '0;
            last_found_reg <= 1'b0;
            p_valid_reg    <= 1'b0;
            o_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            depth_reg      <= depth_next;
            last_found_reg <= last_found_next;
            p_valid_reg    <= p_valid_next;
            o_valid_reg    <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sweep_reg    <= sweep_next;
        wall0_reg    <= wall0_next;
        w_reg        <= w_next;
        h_reg        <= h_next;
        end_reg      <= end_next;
        top_reg      <= top_next;
        nb_reg       <= nb_next;
        p_action_reg <= p_action_next;
        p_range_reg  <= p_range_next;
        o_found_reg  <= o_found_next;
        o_mark_reg   <= o_mark_next;
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(depth_reg) <= 32'(CELLS))
        else $error("stack depth beyond cell count");

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> state_reg == ST_IDLE)
        else $error("request taken while search busy");

    a_solve_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && req.action == ACT_SOLVE) |=> state_reg == ST_CLEAR)
        else $error("solve request did not start clearing pass");

    a_step_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEP || state_reg == ST_CHECK || state_reg == ST_POP)
            |-> depth_reg != '0)
        else $error("search step with empty stack");

    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> depth_reg == '0)
        else $error("stack not emptied after solve");

endmodule
